// ----- rtl/usc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 sanitizing copy block.
package usc_pkg;

   localparam int CAP_W = 13;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic [12:0] CAP_DEFAULT = 13'd128;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUESTION = 8'h3f;
   localparam logic [7:0] CHAR_DEL = 8'h7f;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   localparam logic [7:0] LEAD2_LO = 8'hc2;
   localparam logic [7:0] LEAD2_HI = 8'hdf;
   localparam logic [7:0] LEAD3_LO = 8'he0;
   localparam logic [7:0] LEAD3_HI = 8'hef;
   localparam logic [7:0] LEAD4_LO = 8'hf0;
   localparam logic [7:0] LEAD4_HI = 8'hf4;

   localparam logic [20:0] CP_MIN2 = 21'h80;
   localparam logic [20:0] CP_MIN3 = 21'h800;
   localparam logic [20:0] CP_MIN4 = 21'h10000;
   localparam logic [20:0] CP_MAX = 21'h10ffff;
   localparam logic [20:0] SURR_LO = 21'hd800;
   localparam logic [20:0] SURR_HI = 21'hdfff;
   localparam logic [20:0] C1_LO = 21'h80;
   localparam logic [20:0] C1_HI = 21'h9f;

   localparam logic [2:0] SEQ_LEN2 = 3'd2;
   localparam logic [2:0] SEQ_LEN3 = 3'd3;
   localparam logic [2:0] SEQ_LEN4 = 3'd4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // Up to four output bytes produced by one input transaction.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
      logic            last;
   } work_type;

endpackage

// ----- rtl/usc_queue.sv -----
`timescale 1ns / 1ps
// Small register queue between the classifying front end and the byte emitter.
module usc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  usc_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output usc_pkg::work_type pop_data,
   output logic              empty
);
   import usc_pkg::*;

   work_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/usc_front.sv -----
`timescale 1ns / 1ps
// Front end: capacity register, UTF-8 decode state and per-transaction output list.
module usc_front #(
   parameter int MAX_CAPACITY = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [12:0]       csr_data,
   input  logic              accept,
   input  usc_pkg::req_type  req_data,
   output logic              q_push,
   output usc_pkg::work_type q_data
);
   import usc_pkg::*;

   localparam logic [16:0] MaxCap = 17'(MAX_CAPACITY);
   localparam logic [12:0] CapReset =
      (MAX_CAPACITY < 128) ? 13'(MAX_CAPACITY) : CAP_DEFAULT;

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [7:0]       hb_ff [3];
   logic [7:0]       hb_in [3];
   logic [1:0]       hc_ff, hc_in;
   logic [2:0]       el_ff, el_in;
   logic [20:0]      cp_ff, cp_in;
   logic [CAP_W-1:0] wr_ff, wr_in;
   logic             full_ff, full_in;

   logic [13:0]      wr_plus1;
   logic [13:0]      rem;
   logic [2:0]       used;
   logic [1:0]       flush_n;
   logic             do_fresh;
   logic             is_cont;
   logic [20:0]      cp_next;
   logic             bad;
   logic [3:0][7:0]  seq;
   logic [7:0]       b;
   work_type         item;

   assign csr_ready = 1'b1;

   // Capacity is clamped once, when written.
   always_comb begin
      if (csr_data == '0) begin
         cap_in = 13'd1;
      end else if ({4'b0, csr_data} > MaxCap) begin
         cap_in = MaxCap[12:0];
      end else begin
         cap_in = csr_data;
      end
   end

   // Number of characters that still fit before the closing NUL.
   assign wr_plus1 = {1'b0, wr_ff} + 14'd1;
   assign rem = (wr_plus1 < {1'b0, cap_ff}) ? ({1'b0, cap_ff} - wr_plus1) : '0;

   assign b = req_data.text_byte;
   assign is_cont = (b[7:6] == 2'b10);
   assign cp_next = {cp_ff[14:0], b[5:0]};

   always_comb begin
      seq[0] = (hc_ff > 2'd0) ? hb_ff[0] : b;
      seq[1] = (hc_ff > 2'd1) ? hb_ff[1] : b;
      seq[2] = (hc_ff > 2'd2) ? hb_ff[2] : b;
      seq[3] = b;
   end

   always_comb begin
      bad = ((el_ff == SEQ_LEN2) && (cp_next < CP_MIN2)) ||
            ((el_ff == SEQ_LEN3) && (cp_next < CP_MIN3)) ||
            ((el_ff == SEQ_LEN4) && (cp_next < CP_MIN4)) ||
            (cp_next > CP_MAX) ||
            ((cp_next >= SURR_LO) && (cp_next <= SURR_HI));
   end

   always_comb begin
      hb_in = hb_ff;
      hc_in = hc_ff;
      el_in = el_ff;
      cp_in = cp_ff;
      full_in = full_ff;
      item.bytes = '0;
      item.count = '0;
      item.last = 1'b0;
      used = '0;
      flush_n = '0;
      do_fresh = 1'b0;

      if (req_data.end_of_text) begin
         flush_n = hc_ff;
      end else if (hc_ff != '0) begin
         if (!is_cont) begin
            flush_n = hc_ff;
            do_fresh = 1'b1;
         end
      end else begin
         do_fresh = 1'b1;
      end

      // A broken or flushed sequence gives one '?' per held byte.
      if (flush_n != '0) begin
         hc_in = '0;
         el_in = '0;
         cp_in = '0;
      end
      for (int k = 0; k < 3; k++) begin
         if ((2'(k) < flush_n) && !full_in) begin
            if ({11'b0, used} >= rem) begin
               full_in = 1'b1;
            end else begin
               item.bytes[item.count[1:0]] = CHAR_QUESTION;
               item.count = item.count + 3'd1;
               used = used + 3'd1;
            end
         end
      end

      if (do_fresh && !full_in) begin
         if ({11'b0, used} >= rem) begin
            full_in = 1'b1;
         end else if (!b[7]) begin
            item.bytes[item.count[1:0]] =
               ((b < CHAR_SPACE) || (b == CHAR_DEL)) ? CHAR_SPACE : b;
            item.count = item.count + 3'd1;
            used = used + 3'd1;
         end else if ((b >= LEAD2_LO) && (b <= LEAD2_HI)) begin
            el_in = SEQ_LEN2;
            cp_in = {16'b0, b[4:0]};
            hb_in[0] = b;
            hc_in = 2'd1;
         end else if ((b >= LEAD3_LO) && (b <= LEAD3_HI)) begin
            el_in = SEQ_LEN3;
            cp_in = {17'b0, b[3:0]};
            hb_in[0] = b;
            hc_in = 2'd1;
         end else if ((b >= LEAD4_LO) && (b <= LEAD4_HI)) begin
            el_in = SEQ_LEN4;
            cp_in = {18'b0, b[2:0]};
            hb_in[0] = b;
            hc_in = 2'd1;
         end else begin
            item.bytes[item.count[1:0]] = CHAR_QUESTION;
            item.count = item.count + 3'd1;
            used = used + 3'd1;
         end
      end

      if (!req_data.end_of_text && (hc_ff != '0) && is_cont) begin
         cp_in = cp_next;
         if (({1'b0, hc_ff} + 3'd1) < el_ff) begin
            case (hc_ff)
               2'd1: hb_in[1] = b;
               2'd2: hb_in[2] = b;
               default: hb_in[0] = b;
            endcase
            hc_in = hc_ff + 2'd1;
         end else begin
            hc_in = '0;
            el_in = '0;
            cp_in = '0;
            if (bad) begin
               for (int k = 0; k < 4; k++) begin
                  if ((3'(k) < el_ff) && !full_in) begin
                     if ({11'b0, used} >= rem) begin
                        full_in = 1'b1;
                     end else begin
                        item.bytes[item.count[1:0]] = CHAR_QUESTION;
                        item.count = item.count + 3'd1;
                        used = used + 3'd1;
                     end
                  end
               end
            end else if ((cp_next >= C1_LO) && (cp_next <= C1_HI)) begin
               if (!full_in) begin
                  if (rem == '0) begin
                     full_in = 1'b1;
                  end else begin
                     item.bytes[0] = CHAR_SPACE;
                     item.count = 3'd1;
                     used = 3'd1;
                  end
               end
            end else if (!full_in) begin
               // The whole sequence must fit below the capacity.
               if ({11'b0, el_ff - 3'd1} >= rem) begin
                  full_in = 1'b1;
               end else begin
                  item.bytes = seq;
                  item.count = el_ff;
                  used = el_ff;
               end
            end
         end
      end

      wr_in = wr_ff + CAP_W'(used);

      if (req_data.end_of_text) begin
         item.bytes[item.count[1:0]] = CHAR_NUL;
         item.count = item.count + 3'd1;
         item.last = 1'b1;
         wr_in = '0;
         full_in = 1'b0;
         hc_in = '0;
         el_in = '0;
         cp_in = '0;
      end
   end

   assign q_push = accept && (item.count != '0);
   assign q_data = item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapReset;
         hc_ff <= '0;
         el_ff <= '0;
         cp_ff <= '0;
         wr_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff <= cap_in;
         end
         if (accept) begin
            hc_ff <= hc_in;
            el_ff <= el_in;
            cp_ff <= cp_in;
            wr_ff <= wr_in;
            full_ff <= full_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hb_ff <= hb_in;
      end
   end

endmodule

// ----- rtl/usc_back.sv -----
`timescale 1ns / 1ps
// Back end: walks each queued byte list and presents one result byte at a time.
module usc_back (
   input  logic              clock,
   input  logic              reset,
   input  usc_pkg::work_type q_data,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output usc_pkg::rsp_type  rsp_data
);
   import usc_pkg::*;

   work_type   cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       last_byte;
   logic       take;
   logic       load;

   assign last_byte = ({1'b0, idx_ff} == (cur_ff.count - 3'd1));
   assign take = valid_ff && rsp_pop;
   assign load = !valid_ff || (take && last_byte);
   assign q_pop = load && !q_empty;

   assign rsp_empty = !valid_ff;
   assign rsp_data.out_byte = cur_ff.bytes[idx_ff];
   assign rsp_data.out_last = cur_ff.last && last_byte;

   always_comb begin
      cur_in = cur_ff;
      idx_in = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = !q_empty;
         cur_in = q_data;
         idx_in = '0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ----- rtl/utf8_sanitizing_copy.sv -----
`timescale 1ns / 1ps
// UTF-8 sanitizing copy: streaming text cleaner with a bounded output length.
//
// Text bytes enter through a queue-style port (req_push/req_full) and the
// cleaned copy leaves through another (rsp_empty/rsp_pop), one byte per
// transaction. The front end decodes one input byte per cycle and turns it
// into zero to four output bytes; a four-entry queue separates it from the
// back end, which delivers one output byte per cycle while rsp_pop is high.
// An input transaction is therefore taken every cycle while the queue has
// room; an item holds the back end until all of its output bytes are popped,
// so the count of output bytes sets the sustained rate. The capacity
// register (written through csr_valid/csr_ready/csr_data, always ready) is
// clamped to 1..MAX_CAPACITY when written and counts the closing NUL. An
// end-of-text transaction flushes any partial sequence as '?' and always
// ends with a NUL result carrying out_last.
module utf8_sanitizing_copy #(
   parameter int MAX_CAPACITY = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [12:0]      csr_data,
   input  logic             req_push,
   output logic             req_full,
   input  usc_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output usc_pkg::rsp_type rsp_data
);
   import usc_pkg::*;

   work_type push_data;
   work_type pop_data;
   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   logic     accept;

   assign req_full = q_full;
   assign accept = req_push && !q_full;

   usc_front #(
      .MAX_CAPACITY(MAX_CAPACITY)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data),
      .accept   (accept),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (push_data)
   );

   usc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(push_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (pop_data),
      .empty    (q_empty)
   );

   usc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (pop_data),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule
